FILE: hdl/gif_line_palette_span_writer_defines.svh
// ----------------------------------------------------------------------------
// gif_line_palette_span_writer_defines
// Assertion macros shared by the span writer's queue and back modules.
// ----------------------------------------------------------------------------
`ifndef GIF_LINE_PALETTE_SPAN_WRITER_DEFINES_SVH
`define GIF_LINE_PALETTE_SPAN_WRITER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define GLPSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define GLPSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/glpsw_pkg.sv
// ----------------------------------------------------------------------------
// glpsw_pkg
// Types and constants of the GIF line palette span writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package glpsw_pkg;

  localparam int SCREEN_WIDTH_DEF  = 480;
  localparam int SCREEN_HEIGHT_DEF = 320;
  localparam int SPAN_LIMIT_DEF    = 256;

  localparam int COORD_W = 12;
  localparam int FWID_W  = 13;
  localparam int IDX_W   = 8;
  localparam int COLOR_W = 16;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 13;

  localparam int QDEPTH = 4;
  localparam int ODEPTH = 4;

  localparam logic CMD_PAL_WRITE = 1'b0;
  localparam logic CMD_PIXEL     = 1'b1;

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAME_LEFT   = 3'd0,
    REG_FRAME_TOP    = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_TRANSP_INDEX = 3'd3,
    REG_BG_INDEX     = 3'd4,
    REG_RESTORE_BG   = 3'd5,
    REG_USE_TRANSP   = 3'd6
  } cfg_reg_e;

  // classified beat from front to back
  typedef struct packed {
    logic               is_write;
    logic [IDX_W-1:0]   addr;
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               start;
  } fe_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               start;
  } out_item_t;

endpackage

FILE: hdl/glpsw_front.sv
// ----------------------------------------------------------------------------
// glpsw_front
// Config registers, column and span tracking, clipping and transparency.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module glpsw_front #(
  parameter int SCREEN_WIDTH  = glpsw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = glpsw_pkg::SCREEN_HEIGHT_DEF,
  parameter int SPAN_LIMIT    = glpsw_pkg::SPAN_LIMIT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [glpsw_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [glpsw_pkg::CFG_DW-1:0]      cfg_data,
  input  logic                              in_accept,
  input  logic                              in_cmd,
  input  logic [glpsw_pkg::IDX_W-1:0]       in_pixel_index,
  input  logic [glpsw_pkg::COORD_W-1:0]     in_line,
  input  logic [glpsw_pkg::COLOR_W-1:0]     in_palette_color,
  output logic                              q_push,
  output glpsw_pkg::fe_item_t               q_item
);

  localparam int SCW = $clog2(SPAN_LIMIT + 1);

  logic [glpsw_pkg::COORD_W-1:0] frame_left_r, frame_top_r;
  logic [glpsw_pkg::FWID_W-1:0]  frame_width_r;
  logic [glpsw_pkg::IDX_W-1:0]   transp_idx_r, bg_idx_r;
  logic                          restore_r, use_transp_r;

  logic [glpsw_pkg::COORD_W-1:0] column_r, column_nxt;
  logic [SCW-1:0]                span_cnt_r, span_cnt_nxt;
  logic                          in_span_r, in_span_nxt;

  logic [glpsw_pkg::FWID_W-1:0]  sx, sy, col_inc;
  logic [glpsw_pkg::IDX_W-1:0]   idx_eff;
  logic                          clip, transp, start, drop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_left_r  <= '0;
      frame_top_r   <= '0;
      frame_width_r <= glpsw_pkg::FWID_W'(1);
      transp_idx_r  <= '0;
      bg_idx_r      <= '0;
      restore_r     <= 1'b0;
      use_transp_r  <= 1'b0;
    end else if (cfg_we) begin
      case (glpsw_pkg::cfg_reg_e'(cfg_index))
        glpsw_pkg::REG_FRAME_LEFT:   frame_left_r  <= cfg_data[glpsw_pkg::COORD_W-1:0];
        glpsw_pkg::REG_FRAME_TOP:    frame_top_r   <= cfg_data[glpsw_pkg::COORD_W-1:0];
        glpsw_pkg::REG_FRAME_WIDTH:  frame_width_r <= cfg_data[glpsw_pkg::FWID_W-1:0];
        glpsw_pkg::REG_TRANSP_INDEX: transp_idx_r  <= cfg_data[glpsw_pkg::IDX_W-1:0];
        glpsw_pkg::REG_BG_INDEX:     bg_idx_r      <= cfg_data[glpsw_pkg::IDX_W-1:0];
        glpsw_pkg::REG_RESTORE_BG:   restore_r     <= cfg_data[0];
        glpsw_pkg::REG_USE_TRANSP:   use_transp_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sx      = {1'b0, frame_left_r} + {1'b0, column_r};
    sy      = {1'b0, frame_top_r} + {1'b0, in_line};
    col_inc = {1'b0, column_r} + glpsw_pkg::FWID_W'(1);
    clip    = (sy >= glpsw_pkg::FWID_W'(SCREEN_HEIGHT)) ||
              (sx >= glpsw_pkg::FWID_W'(SCREEN_WIDTH));
    idx_eff = (restore_r && (in_pixel_index == transp_idx_r)) ? bg_idx_r : in_pixel_index;
    transp  = !restore_r && use_transp_r && (in_pixel_index == transp_idx_r);
    drop    = clip || transp;
    start   = (column_r == '0) || !in_span_r || (span_cnt_r >= SCW'(SPAN_LIMIT));

    if (col_inc >= frame_width_r || col_inc[glpsw_pkg::COORD_W]) begin
      column_nxt = '0;
    end else begin
      column_nxt = col_inc[glpsw_pkg::COORD_W-1:0];
    end

    if (drop) begin
      in_span_nxt  = 1'b0;
      span_cnt_nxt = '0;
    end else begin
      in_span_nxt  = 1'b1;
      span_cnt_nxt = start ? SCW'(1) : span_cnt_r + SCW'(1);
    end

    q_push          = in_accept && ((in_cmd == glpsw_pkg::CMD_PAL_WRITE) || !drop);
    q_item.is_write = (in_cmd == glpsw_pkg::CMD_PAL_WRITE);
    q_item.addr     = (in_cmd == glpsw_pkg::CMD_PAL_WRITE) ? in_pixel_index : idx_eff;
    q_item.color    = in_palette_color;
    q_item.x        = sx[glpsw_pkg::COORD_W-1:0];
    q_item.y        = sy[glpsw_pkg::COORD_W-1:0];
    q_item.start    = start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      span_cnt_r <= '0;
      in_span_r  <= 1'b0;
    end else if (in_accept && (in_cmd == glpsw_pkg::CMD_PIXEL)) begin
      column_r   <= column_nxt;
      span_cnt_r <= span_cnt_nxt;
      in_span_r  <= in_span_nxt;
    end
  end

endmodule

FILE: hdl/glpsw_queue.sv
// ----------------------------------------------------------------------------
// glpsw_queue
// Short FIFO of classified beats between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gif_line_palette_span_writer_defines.svh"

module glpsw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  glpsw_pkg::fe_item_t  push_item,
  input  logic                 pop,
  output glpsw_pkg::fe_item_t  head,
  output glpsw_pkg::q_status_t status
);

  localparam int PW = $clog2(glpsw_pkg::QDEPTH);
  localparam int CW = $clog2(glpsw_pkg::QDEPTH + 1);

  glpsw_pkg::fe_item_t mem_r [glpsw_pkg::QDEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [CW-1:0] cnt_r;

  assign status.full  = (cnt_r == CW'(glpsw_pkg::QDEPTH));
  assign status.empty = (cnt_r == '0);
  assign head         = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + PW'(1);
      if (pop)  rptr_r <= rptr_r + PW'(1);
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + CW'(1);
        2'b01:   cnt_r <= cnt_r - CW'(1);
        default: ;
      endcase
    end
  end

  `GLPSW_ASSERT_NOW(a_q_no_overflow, push, !status.full, "queue pushed while full")
  `GLPSW_ASSERT_NOW(a_q_no_underflow, pop, !status.empty, "queue popped while empty")
  `GLPSW_ASSERT_NEXT(a_q_fill, push && !pop && !status.full, !status.empty,
                     "queue empty after a push")

endmodule

FILE: hdl/glpsw_back.sv
// ----------------------------------------------------------------------------
// glpsw_back
// Palette store, colour lookup and result FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gif_line_palette_span_writer_defines.svh"

module glpsw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  glpsw_pkg::fe_item_t           q_head,
  input  glpsw_pkg::q_status_t          q_status,
  output logic                          q_pop,
  input  logic                          out_pop,
  output logic                          out_empty,
  output logic [glpsw_pkg::COLOR_W-1:0] out_pixel_color,
  output logic [glpsw_pkg::COORD_W-1:0] out_screen_x,
  output logic [glpsw_pkg::COORD_W-1:0] out_screen_y,
  output logic                          out_starts_span
);

  localparam int PAL_DEPTH = 1 << glpsw_pkg::IDX_W;
  localparam int PW = $clog2(glpsw_pkg::ODEPTH);
  localparam int CW = $clog2(glpsw_pkg::ODEPTH + 1);

  logic [glpsw_pkg::COLOR_W-1:0] pal_mem [PAL_DEPTH];

  logic                          s1_valid_r;
  logic [glpsw_pkg::COLOR_W-1:0] rd_data_r;
  logic [glpsw_pkg::COORD_W-1:0] s1_x_r, s1_y_r;
  logic                          s1_start_r;

  glpsw_pkg::out_item_t ofifo_r [glpsw_pkg::ODEPTH];
  glpsw_pkg::out_item_t o_head;
  logic [PW-1:0] owptr_r, orptr_r;
  logic [CW-1:0] ocnt_r;

  logic room, issue, issue_rd, o_pop;

  always_comb begin
    room     = ({1'b0, ocnt_r} + {{CW{1'b0}}, s1_valid_r}) < (CW+1)'(glpsw_pkg::ODEPTH);
    issue    = !q_status.empty && (q_head.is_write || room);
    issue_rd = issue && !q_head.is_write;
    q_pop    = issue;
    o_pop    = out_pop && !out_empty;
  end

  always_ff @(posedge clk) begin
    if (issue && q_head.is_write) begin
      pal_mem[q_head.addr] <= q_head.color;
    end
    if (issue_rd) begin
      rd_data_r  <= pal_mem[q_head.addr];
      s1_x_r     <= q_head.x;
      s1_y_r     <= q_head.y;
      s1_start_r <= q_head.start;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      ofifo_r[owptr_r] <= '{color: rd_data_r, x: s1_x_r, y: s1_y_r, start: s1_start_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      owptr_r    <= '0;
      orptr_r    <= '0;
      ocnt_r     <= '0;
    end else begin
      s1_valid_r <= issue_rd;
      if (s1_valid_r) owptr_r <= owptr_r + PW'(1);
      if (o_pop)      orptr_r <= orptr_r + PW'(1);
      case ({s1_valid_r, o_pop})
        2'b10:   ocnt_r <= ocnt_r + CW'(1);
        2'b01:   ocnt_r <= ocnt_r - CW'(1);
        default: ;
      endcase
    end
  end

  assign o_head          = ofifo_r[orptr_r];
  assign out_empty       = (ocnt_r == '0);
  assign out_pixel_color = o_head.color;
  assign out_screen_x    = o_head.x;
  assign out_screen_y    = o_head.y;
  assign out_starts_span = o_head.start;

  `GLPSW_ASSERT_NOW(a_b_room, s1_valid_r, ocnt_r < CW'(glpsw_pkg::ODEPTH),
                    "lookup completed with result FIFO full")
  `GLPSW_ASSERT_NEXT(a_b_lookup, issue_rd, s1_valid_r, "palette lookup lost")
  `GLPSW_ASSERT_NEXT(a_b_hold, !out_empty && !out_pop, !out_empty,
                     "waiting result vanished")

endmodule

FILE: hdl/gif_line_palette_span_writer.sv
// ----------------------------------------------------------------------------
// gif_line_palette_span_writer
// Palette-indexed GIF line pixels to clipped RGB565 screen pixels with spans.
// ----------------------------------------------------------------------------
//  channel  direction  beat                                  handshake
//  in       input      cmd, pixel_index, line, palette_color push / full
//  out      output     pixel_color, screen_x, screen_y, span empty / pop
//  cfg      input      index, data                           valid / ready
//
//  One beat per clock in both directions unless in_full or a full result FIFO
//  holds it; a result passes the queue, palette read and result FIFO in turn.
//  The palette RAM's single registered read port sets the one-per-clock rate.
//  Reset is synchronous; palette contents are not cleared.
//  Front and back are decoupled by a 4-entry queue; the result FIFO holds 4.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gif_line_palette_span_writer #(
  parameter int SCREEN_WIDTH  = glpsw_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = glpsw_pkg::SCREEN_HEIGHT_DEF,
  parameter int SPAN_LIMIT    = glpsw_pkg::SPAN_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic                          in_cmd,
  input  logic [glpsw_pkg::IDX_W-1:0]   in_pixel_index,
  input  logic [glpsw_pkg::COORD_W-1:0] in_line,
  input  logic [glpsw_pkg::COLOR_W-1:0] in_palette_color,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [glpsw_pkg::COLOR_W-1:0] out_pixel_color,
  output logic [glpsw_pkg::COORD_W-1:0] out_screen_x,
  output logic [glpsw_pkg::COORD_W-1:0] out_screen_y,
  output logic                          out_starts_span,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [glpsw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [glpsw_pkg::CFG_DW-1:0]  cfg_data
);

  glpsw_pkg::fe_item_t  push_item, q_head;
  glpsw_pkg::q_status_t q_status;
  logic                 in_accept, q_push, q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_status.full;
  assign in_accept = in_push && !q_status.full;

  glpsw_front #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .SPAN_LIMIT   (SPAN_LIMIT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_accept       (in_accept),
    .in_cmd          (in_cmd),
    .in_pixel_index  (in_pixel_index),
    .in_line         (in_line),
    .in_palette_color(in_palette_color),
    .q_push          (q_push),
    .q_item          (push_item)
  );

  glpsw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(push_item),
    .pop      (q_pop),
    .head     (q_head),
    .status   (q_status)
  );

  glpsw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_status       (q_status),
    .q_pop          (q_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_pixel_color(out_pixel_color),
    .out_screen_x   (out_screen_x),
    .out_screen_y   (out_screen_y),
    .out_starts_span(out_starts_span)
  );

endmodule
